@@ rtl/socc_pkg.sv @@
// Shared types, constants and arithmetic helpers for the stereo one-corner soft clipper.
package socc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int ST_W        = SAMPLE_BITS + 4;      // channel state / processed value
    localparam int THR_W       = SAMPLE_BITS - 1;      // threshold magnitude
    localparam int GAIN_W      = 20;                   // Q4.16
    localparam int FRAC_W      = 16;
    localparam int Q_W         = FRAC_W + 1;           // Q0.16 with room for 1.0
    localparam int ACC_W       = ST_W + 20;            // product sums before rounding
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = (THR_W > GAIN_W) ? THR_W : GAIN_W;

    localparam int PG_W = SAMPLE_BITS + GAIN_W + 1;    // sample * gain
    localparam int PA_W = ST_W + Q_W + 1;              // last * voicing
    localparam int PT_W = THR_W + Q_W;                 // threshold * (1 - voicing)
    localparam int MW_W = ST_W + Q_W + 1;              // processed * wet
    localparam int MD_W = SAMPLE_BITS + Q_W + 1;       // dry * (1 - wet)

    localparam logic [Q_W-1:0]    Q_UNITY    = Q_W'(1) << FRAC_W;
    localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1) << FRAC_W;
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_UNITY;
    localparam logic [THR_W-1:0]  THR_RESET  = '1;
    localparam logic [Q_W-1:0]    VOICING_RESET = Q_W'(40503);
    localparam logic [Q_W-1:0]    WET_RESET  = Q_UNITY;

    localparam logic signed [ST_W-1:0] POS_T_RESET = $signed(ST_W'(THR_RESET));
    localparam logic signed [ST_W-1:0] NEG_T_RESET = -$signed(ST_W'(THR_RESET));

    localparam logic signed [ST_W-1:0] SAT_HI =
        {{(ST_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ST_W-1:0] SAT_LO = ~SAT_HI;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (FRAC_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INPUT_GAIN = 3'd0,
        REG_POS_THR    = 3'd1,
        REG_NEG_THR    = 3'd2,
        REG_VOICING    = 3'd3,
        REG_WET_MIX    = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLIP,
        ST_MIX,
        ST_SUM
    } t_state;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic              gain_unity;
        logic [THR_W-1:0]  pos_thr;
        logic [THR_W-1:0]  neg_thr;
        logic [Q_W-1:0]    voicing;      // clamped to 1.0
        logic [Q_W-1:0]    voicing_inv;  // 1.0 - voicing
        logic [Q_W-1:0]    wet;          // clamped to 1.0
        logic [Q_W-1:0]    wet_inv;      // 1.0 - wet
    } t_cfg;

    typedef struct packed {
        logic load;   // beat accepted: capture sample, first products
        logic clip;   // clip decision, state update
        logic mix;    // wet/dry products
    } t_lane_ctl;

    typedef struct packed {
        logic [ST_W-1:0]        mix;   // rounded wet/dry sum, before saturation
        logic [SAMPLE_BITS-1:0] dry;
        logic                   hit;
    } t_lane_res;

    // floor((a + 2^15) / 2^16); result known to fit ST_W
    function automatic logic signed [ST_W-1:0] rnd16(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] s;
        begin
            t = a + ROUND_BIAS;
            s = t >>> FRAC_W;
            return s[ST_W-1:0];
        end
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [ST_W-1:0] m);
        logic signed [ST_W-1:0] c;
        begin
            if (m > SAT_HI) begin
                c = SAT_HI;
            end else if (m < SAT_LO) begin
                c = SAT_LO;
            end else begin
                c = m;
            end
            return c[SAMPLE_BITS-1:0];
        end
    endfunction

endpackage

@@ rtl/socc_cfg.sv @@
// Configuration register file with voicing and wet clamping.
module socc_cfg import socc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [GAIN_W-1:0] r_gain;
    logic [THR_W-1:0]  r_pos_thr;
    logic [THR_W-1:0]  r_neg_thr;
    logic [Q_W-1:0]    r_voicing;
    logic [Q_W-1:0]    r_wet;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= GAIN_RESET;
            r_pos_thr <= THR_RESET;
            r_neg_thr <= THR_RESET;
            r_voicing <= VOICING_RESET;
            r_wet     <= WET_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_INPUT_GAIN: r_gain    <= i_cfg_data[GAIN_W-1:0];
                REG_POS_THR:    r_pos_thr <= i_cfg_data[THR_W-1:0];
                REG_NEG_THR:    r_neg_thr <= i_cfg_data[THR_W-1:0];
                REG_VOICING:    r_voicing <= i_cfg_data[Q_W-1:0];
                REG_WET_MIX:    r_wet     <= i_cfg_data[Q_W-1:0];
                default: ;      // unmapped index: ignored
            endcase
        end
    end

    always_comb begin
        o_cfg.gain        = r_gain;
        o_cfg.gain_unity  = (r_gain == GAIN_UNITY);
        o_cfg.pos_thr     = r_pos_thr;
        o_cfg.neg_thr     = r_neg_thr;
        o_cfg.voicing     = (r_voicing > Q_UNITY) ? Q_UNITY : r_voicing;
        o_cfg.voicing_inv = Q_UNITY - o_cfg.voicing;
        o_cfg.wet         = (r_wet > Q_UNITY) ? Q_UNITY : r_wet;
        o_cfg.wet_inv     = Q_UNITY - o_cfg.wet;
    end

endmodule

@@ rtl/socc_lane.sv @@
// One channel lane: gain, one-corner clip with target tracking, wet/dry products.
module socc_lane import socc_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_lane_ctl                     i_ctl,
    input  t_cfg                          i_cfg,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output t_lane_res                     o_res
);

    // channel state
    logic signed [ST_W-1:0] r_last;
    logic signed [ST_W-1:0] r_pos_t;
    logic signed [ST_W-1:0] r_neg_t;

    // per-beat datapath
    logic signed [SAMPLE_BITS-1:0] r_dry;
    logic signed [PG_W-1:0]        r_pg;
    logic signed [PA_W-1:0]        r_pa;
    logic        [PT_W-1:0]        r_pp;
    logic        [PT_W-1:0]        r_pn;
    logic signed [ST_W-1:0]        r_proc;
    logic                          r_hit;
    logic signed [MW_W-1:0]        r_mw;
    logic signed [MD_W-1:0]        r_md;

    logic signed [ST_W-1:0] gained;
    logic signed [ST_W-1:0] cand_p;
    logic signed [ST_W-1:0] cand_n;
    logic signed [ST_W-1:0] pth;
    logic signed [ST_W-1:0] nth;
    logic signed [ST_W-1:0] x_p;
    logic signed [ST_W-1:0] n_last;
    logic signed [ST_W-1:0] n_pos_t;
    logic signed [ST_W-1:0] n_neg_t;
    logic                   hit_p;
    logic                   hit_n;

    always_comb begin
        gained = rnd16(ACC_W'(r_pg));
        cand_p = rnd16(ACC_W'(r_pa) + $signed(ACC_W'(r_pp)));
        cand_n = rnd16(ACC_W'(r_pa) - $signed(ACC_W'(r_pn)));
        pth    = $signed(ST_W'(i_cfg.pos_thr));
        nth    = -$signed(ST_W'(i_cfg.neg_thr));

        hit_p   = (gained > r_pos_t);
        x_p     = hit_p ? cand_p : gained;
        n_pos_t = hit_p ? cand_p : pth;

        // negative side tests the value after the positive side
        hit_n   = (x_p < r_neg_t);
        n_last  = hit_n ? cand_n : x_p;
        n_neg_t = hit_n ? cand_n : nth;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_pos_t <= POS_T_RESET;
            r_neg_t <= NEG_T_RESET;
        end else if (i_ctl.clip) begin
            r_last  <= n_last;
            r_pos_t <= n_pos_t;
            r_neg_t <= n_neg_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_dry <= i_sample;
            r_pg  <= i_sample * $signed({1'b0, i_cfg.gain});
            r_pa  <= r_last * $signed({1'b0, i_cfg.voicing});
            r_pp  <= i_cfg.pos_thr * i_cfg.voicing_inv;
            r_pn  <= i_cfg.neg_thr * i_cfg.voicing_inv;
        end
        if (i_ctl.clip) begin
            r_proc <= n_last;
            r_hit  <= hit_p | hit_n;
        end
        if (i_ctl.mix) begin
            r_mw <= r_proc * $signed({1'b0, i_cfg.wet});
            r_md <= r_dry * $signed({1'b0, i_cfg.wet_inv});
        end
    end

    always_comb begin
        o_res.mix = rnd16(ACC_W'(r_mw) + ACC_W'(r_md));
        o_res.dry = r_dry;
        o_res.hit = r_hit;
    end

endmodule

@@ rtl/socc_merge.sv @@
// Merge stage: saturation, unity bypass across both lanes, output register.
module socc_merge import socc_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic                          i_gain_unity,
    input  t_lane_res                     i_left,
    input  t_lane_res                     i_right,
    input  logic                          i_out_stall,
    output logic                          o_free,
    output logic                          o_out_valid,
    output logic signed [SAMPLE_BITS-1:0] o_left_out,
    output logic signed [SAMPLE_BITS-1:0] o_right_out
);

    logic                          r_valid;
    logic signed [SAMPLE_BITS-1:0] r_left;
    logic signed [SAMPLE_BITS-1:0] r_right;
    logic                          bypass;

    assign o_free = !r_valid || !i_out_stall;
    assign bypass = i_gain_unity && !(i_left.hit || i_right.hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_left  <= bypass ? $signed(i_left.dry)  : sat($signed(i_left.mix));
            r_right <= bypass ? $signed(i_right.dry) : sat($signed(i_right.mix));
        end
    end

    assign o_out_valid = r_valid;
    assign o_left_out  = r_left;
    assign o_right_out = r_right;

endmodule

@@ rtl/stereo_one_corner_soft_clipper_core.sv @@
// Stereo one-corner soft clipper: top level with beat sequencer and two channel lanes.
//
// One stereo frame per beat. Each channel runs in its own lane: input gain, a
// one-corner clip against tracking positive/negative targets (a clipped sample
// becomes last*voicing + threshold*(1-voicing) and the target follows it; an
// unclipped side reloads its threshold), then a wet/dry mix. A merge stage
// saturates both results to the sample range and passes the raw inputs through
// when the gain is exactly unity and neither channel clipped. From acceptance to
// its result beat a frame goes through product capture, clip decision and state
// update, wet/dry products, round/saturate into the output register. The sequencer
// handles one frame at a time; a new frame is accepted once the last result has
// gone in; the input is open again while a finished result still waits on the
// output stall, and the output register holds it until taken. Configuration
// writes (index 0 gain, 1 positive threshold, 2 negative threshold, 3 voicing,
// 4 wet mix) are always ready and should only be issued while the block is idle.
module stereo_one_corner_soft_clipper_core import socc_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input frames
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_right_sample,
    // result frames
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_left_out,
    output logic signed [SAMPLE_BITS-1:0] o_right_out,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    t_state    r_state;
    t_state    n_state;
    t_lane_ctl ctl;
    t_cfg      cfg;
    t_lane_res res_l;
    t_lane_res res_r;
    logic      merge_free;
    logic      merge_load;
    logic      accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer: one frame in flight, result waits in ST_SUM for a free output
    always_comb begin
        n_state    = r_state;
        ctl.load   = 1'b0;
        ctl.clip   = 1'b0;
        ctl.mix    = 1'b0;
        merge_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    ctl.load = 1'b1;
                    n_state  = ST_CLIP;
                end
            end
            ST_CLIP: begin
                ctl.clip = 1'b1;
                n_state  = ST_MIX;
            end
            ST_MIX: begin
                ctl.mix = 1'b1;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                if (merge_free) begin
                    merge_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    socc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    socc_lane u_lane_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_cfg    (cfg),
        .i_sample (i_left_sample),
        .o_res    (res_l)
    );

    socc_lane u_lane_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_cfg    (cfg),
        .i_sample (i_right_sample),
        .o_res    (res_r)
    );

    socc_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (merge_load),
        .i_gain_unity (cfg.gain_unity),
        .i_left       (res_l),
        .i_right      (res_r),
        .i_out_stall  (i_out_stall),
        .o_free       (merge_free),
        .o_out_valid  (o_out_valid),
        .o_left_out   (o_left_out),
        .o_right_out  (o_right_out)
    );

endmodule

@@ verif/tb_stereo_one_corner_soft_clipper_core.sv @@
// Self-checking testbench for the stereo one-corner soft clipper core.
module tb_stereo_one_corner_soft_clipper_core;
    import socc_pkg::*;

    // ------------------------------------------------------------------
    // Constants of the checker
    // ------------------------------------------------------------------
    localparam longint UNITY_Q16   = 65536;
    localparam longint SAMPLE_MAX  = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN  = -SAMPLE_MAX - 1;
    localparam longint THR_MAX     = (longint'(1) << THR_W) - 1;
    // reset values of the register file, per the block description
    localparam longint GAIN_POR    = 65536;
    localparam longint THR_POR     = 8388607;
    localparam longint VOICING_POR = 40503;
    localparam longint WET_POR     = 65536;
    // indexes that decode to no register; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    // cycles with no beat on any channel before the run is declared hung
    localparam int WATCHDOG_LIMIT  = 5000;
    // clocks waited after the last result so that config writes land on an idle block
    localparam int SETTLE_CYCLES   = 12;
    localparam int RANDOM_PHASES   = 14;
    localparam int FRAMES_PER_PHASE = 125;

    typedef enum int {
        PACE_NONE,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } pacing_t;

    typedef enum int {
        SIG_FULL,    // any 24-bit pattern
        SIG_QUIET,   // small signal, within -4096..4095
        SIG_LOUD,    // near full scale, meant to keep the clipper engaged
        SIG_KNEE     // hovers around the effective clip level
    } sig_style_t;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
    } frame_t;

    typedef struct {
        frame_t frame;
        bit     drain_first;   // hold off until every expected frame has come back
    } send_item_t;

    // ------------------------------------------------------------------
    // DUT connections, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_in_valid     = 1'b0;
    logic                          o_in_stall;
    logic signed [SAMPLE_BITS-1:0] i_left_sample  = '0;
    logic signed [SAMPLE_BITS-1:0] i_right_sample = '0;
    logic                          o_out_valid;
    logic                          i_out_stall    = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_left_out;
    logic signed [SAMPLE_BITS-1:0] o_right_out;
    logic                          i_cfg_valid    = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data     = '0;

    stereo_one_corner_soft_clipper_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 4 time unit clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 0;
    end

    // ------------------------------------------------------------------
    // Checker state
    // ------------------------------------------------------------------
    send_item_t frames_to_send[$];     // filled by the sequence, drained by the driver
    frame_t     clipped_frames_due[$]; // predicted output frames, oldest first
    int         mismatch_count   = 0;
    int         sender_idle_pct  = 0;
    int         recv_stall_pct   = 0;
    int         quiet_cycles     = 0;

    // Mirror of the register file, updated on each config beat
    longint gain_reg    = GAIN_POR;
    longint pos_thr_reg = THR_POR;
    longint neg_thr_reg = THR_POR;
    longint voicing_reg = VOICING_POR;
    longint wet_reg     = WET_POR;

    // Per-channel clipper memory: index 0 is left, 1 is right
    longint last_val[2]   = '{0, 0};
    longint pos_corner[2] = '{THR_POR, THR_POR};
    longint neg_corner[2] = '{-THR_POR, -THR_POR};

    // floor((a + 2^15) / 2^16): arithmetic shift on a signed 64-bit value is a floor
    function automatic longint q16_round(input longint a);
        return (a + 32768) >>> 16;
    endfunction

    // Work out the output frame for one accepted input frame and advance the
    // clipper memory exactly as the block must.
    task automatic predict_clipped_frame(input frame_t din);
        longint dry [2];
        longint gained;
        longint x;
        longint mixed;
        longint v;
        longint w;
        longint pth;
        longint nth;
        bit     any_clip;
        frame_t dout;
        logic signed [SAMPLE_BITS-1:0] res [2];
        begin
            dry[0]   = din.left;
            dry[1]   = din.right;
            // softness and wet mix above 1.0 behave as 1.0
            v        = (voicing_reg > UNITY_Q16) ? UNITY_Q16 : voicing_reg;
            w        = (wet_reg > UNITY_Q16) ? UNITY_Q16 : wet_reg;
            pth      = pos_thr_reg;
            nth      = -neg_thr_reg;
            any_clip = 1'b0;
            for (int ch = 0; ch < 2; ch++) begin
                gained = q16_round(dry[ch] * gain_reg);
                x      = gained;
                // positive corner: a clip pulls toward the threshold and the
                // corner follows; otherwise the corner reloads the threshold
                if (x > pos_corner[ch]) begin
                    x              = q16_round(last_val[ch] * v + pth * (UNITY_Q16 - v));
                    pos_corner[ch] = x;
                    any_clip       = 1'b1;
                end else begin
                    pos_corner[ch] = pth;
                end
                // negative corner tests the value after the positive side
                if (x < neg_corner[ch]) begin
                    x              = q16_round(last_val[ch] * v + nth * (UNITY_Q16 - v));
                    neg_corner[ch] = x;
                    any_clip       = 1'b1;
                end else begin
                    neg_corner[ch] = nth;
                end
                last_val[ch] = x;
                mixed = q16_round(x * w + dry[ch] * (UNITY_Q16 - w));
                if (mixed > SAMPLE_MAX) begin
                    mixed = SAMPLE_MAX;
                end
                if (mixed < SAMPLE_MIN) begin
                    mixed = SAMPLE_MIN;
                end
                res[ch] = mixed[SAMPLE_BITS-1:0];
            end
            // unity gain with no clip anywhere passes the raw frame through
            if (gain_reg == UNITY_Q16 && !any_clip) begin
                res[0] = din.left;
                res[1] = din.right;
            end
            dout.left  = res[0];
            dout.right = res[1];
            clipped_frames_due.push_back(dout);
        end
    endtask

    task automatic flag_mismatch(input string msg);
        begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("MISMATCH: %s", msg);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Config mirror: follows every write beat, unknown indexes ignored
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_INPUT_GAIN: gain_reg    = i_cfg_data[GAIN_W-1:0];
                REG_POS_THR:    pos_thr_reg = i_cfg_data[THR_W-1:0];
                REG_NEG_THR:    neg_thr_reg = i_cfg_data[THR_W-1:0];
                REG_VOICING:    voicing_reg = i_cfg_data[Q_W-1:0];
                REG_WET_MIX:    wet_reg     = i_cfg_data[Q_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input driver: one decision per edge, a held beat never changes
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        send_item_t nxt;
        bit         holding;
        bit         blocked;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            holding = i_in_valid && o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                predict_clipped_frame('{left: i_left_sample, right: i_right_sample});
            end
            if (!holding) begin
                blocked = 1'b0;
                if (frames_to_send.size() == 0) begin
                    blocked = 1'b1;
                end else if (frames_to_send[0].drain_first && clipped_frames_due.size() != 0) begin
                    blocked = 1'b1;
                end else if ($urandom_range(99) < sender_idle_pct) begin
                    blocked = 1'b1;
                end
                if (blocked) begin
                    i_in_valid <= 1'b0;
                end else begin
                    nxt = frames_to_send.pop_front();
                    i_in_valid     <= 1'b1;
                    i_left_sample  <= nxt.frame.left;
                    i_right_sample <= nxt.frame.right;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: compare each result beat with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        frame_t want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (clipped_frames_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result beat left=%0d right=%0d",
                                            o_left_out, o_right_out));
                end else begin
                    want = clipped_frames_due.pop_front();
                    if (o_left_out !== want.left) begin
                        flag_mismatch($sformatf("left_out expected %0d got %0d",
                                                want.left, o_left_out));
                    end
                    if (o_right_out !== want.right) begin
                        flag_mismatch($sformatf("right_out expected %0d got %0d",
                                                want.right, o_right_out));
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without a beat on any channel means a hang
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("stereo_one_corner_soft_clipper_core verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------
    // One config beat; valid stays up so back-to-back writes need no toggle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint data);
        begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= data[CFG_DATA_W-1:0];
            @(posedge i_clk);
            while (!o_cfg_ready) begin
                @(posedge i_clk);
            end
        end
    endtask

    task automatic load_settings(input longint g, input longint pt, input longint nt,
                                 input longint v, input longint w);
        begin
            write_reg(REG_INPUT_GAIN, g);
            write_reg(REG_POS_THR, pt);
            write_reg(REG_NEG_THR, nt);
            write_reg(REG_VOICING, v);
            write_reg(REG_WET_MIX, w);
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic set_pacing(input pacing_t mode);
        begin
            case (mode)
                PACE_NONE:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                PACE_SEND_IDLE:  begin sender_idle_pct = 62; recv_stall_pct = 0;  end
                PACE_RECV_STALL: begin sender_idle_pct = 0;  recv_stall_pct = 62; end
                default:         begin sender_idle_pct = 20; recv_stall_pct = 20; end
            endcase
        end
    endtask

    task automatic queue_frame(input longint l, input longint r, input bit drain);
        send_item_t it;
        begin
            it.frame.left    = l[SAMPLE_BITS-1:0];
            it.frame.right   = r[SAMPLE_BITS-1:0];
            it.drain_first   = drain;
            frames_to_send.push_back(it);
        end
    endtask

    // Wait for every queued frame to go out and come back, then let the
    // pipeline settle so the next config write lands on an idle block.
    task automatic drain_block();
        begin
            do begin
                @(posedge i_clk);
            end while (frames_to_send.size() != 0 || i_in_valid ||
                       clipped_frames_due.size() != 0);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end
    endtask

    // Input level at which a given threshold starts to clip under the current gain
    function automatic longint knee_level(input longint thr);
        longint k;
        begin
            if (gain_reg == 0) begin
                k = SAMPLE_MAX;
            end else begin
                k = (thr * UNITY_Q16) / gain_reg;
            end
            if (k > SAMPLE_MAX) begin
                k = SAMPLE_MAX;
            end
            return k;
        end
    endfunction

    function automatic longint pick_sample(input sig_style_t style, input bit neg);
        longint s;
        begin
            case (style)
                SIG_FULL: begin
                    s = longint'($signed($urandom_range(32'hFFFF_FFFF, 0) << 8)) >>> 8;
                end
                SIG_QUIET: begin
                    s = longint'($urandom_range(8191)) - 4096;
                end
                SIG_LOUD: begin
                    s = SAMPLE_MAX - longint'($urandom_range(1 << 18));
                    if (neg) begin
                        s = -s - 1;
                    end
                end
                default: begin
                    if (neg) begin
                        s = -knee_level(neg_thr_reg);
                    end else begin
                        s = knee_level(pos_thr_reg);
                    end
                    s = s + longint'($urandom_range(2000)) - 1000;
                end
            endcase
            if (s > SAMPLE_MAX) begin
                s = SAMPLE_MAX;
            end
            if (s < SAMPLE_MIN) begin
                s = SAMPLE_MIN;
            end
            return s;
        end
    endfunction

    // Random program: segments of one signal style per channel, so loud
    // stretches keep the corners tracking while quiet ones release them.
    task automatic queue_program(input int count);
        sig_style_t l_style;
        sig_style_t r_style;
        bit         l_neg;
        bit         r_neg;
        int         seg_left;
        begin
            seg_left = 0;
            l_style  = SIG_FULL;
            r_style  = SIG_FULL;
            l_neg    = 1'b0;
            r_neg    = 1'b0;
            for (int n = 0; n < count; n++) begin
                if (seg_left == 0) begin
                    l_style  = sig_style_t'($urandom_range(3));
                    r_style  = ($urandom_range(2) == 0) ? sig_style_t'($urandom_range(3))
                                                        : l_style;
                    seg_left = $urandom_range(40, 4);
                end
                seg_left--;
                if ($urandom_range(7) == 0) begin
                    l_neg = !l_neg;
                end
                if ($urandom_range(7) == 0) begin
                    r_neg = !r_neg;
                end
                queue_frame(pick_sample(l_style, l_neg), pick_sample(r_style, r_neg),
                            $urandom_range(63) == 0);
            end
        end
    endtask

    function automatic longint pick_threshold();
        case ($urandom_range(4))
            0:       return longint'($urandom_range(32'hFFFF_FFFF, 0)) & THR_MAX;
            1:       return longint'($urandom_range(1 << 20));
            2:       return THR_MAX;
            3:       return longint'($urandom_range(1 << 22, 1 << 20));
            default: return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        longint g;
        longint v;
        longint w;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, unity gain so most frames bypass; the most
        // negative code lies below the negated threshold and must clip.
        set_pacing(PACE_NONE);
        queue_frame(0, 0, 1'b0);
        queue_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        queue_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        queue_frame(1, -1, 1'b0);
        queue_frame(-1, 1, 1'b0);
        queue_frame(24'h555555, -24'sd5592406, 1'b0);
        queue_frame(-24'sd5592406, 24'h555555, 1'b0);
        queue_frame(0, 0, 1'b0);
        drain_block();

        // Hard clip: top gain, low thresholds, zero softness; repeated peaks
        // check that the corner tracks the clipped value.
        load_settings(longint'(20'hFFFFF), 1 << 20, 1 << 20, 0, UNITY_Q16);
        queue_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        queue_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        queue_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        queue_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        queue_frame(0, 0, 1'b0);
        queue_frame(-1, 1, 1'b0);
        drain_block();

        // Zero gain, zero thresholds, softness and wet above one; writes to
        // spare indexes in between must leave the register file alone.
        load_settings(0, 0, 0, 17'h1FFFF, 17'h1FFFF);
        for (int idx = REG_SPARE_LO; idx <= REG_SPARE_HI; idx++) begin
            write_reg(idx[CFG_IDX_W-1:0], longint'($urandom_range(32'hFFFF_FFFF, 0)));
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        queue_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        queue_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        queue_frame(1, -1, 1'b0);
        drain_block();

        // Unity gain with mid thresholds, full softness, fully dry: clipping
        // frames lose the bypass even though the mix returns the dry signal.
        load_settings(UNITY_Q16, 24'h400000, 24'h400000, UNITY_Q16, 0);
        queue_frame(24'h500000, 0, 1'b0);
        queue_frame(24'h500000, -24'sd5242880, 1'b0);
        queue_frame(-24'sd5242880, 0, 1'b0);
        queue_frame(0, 0, 1'b0);
        drain_block();

        // Threshold change while the corners still hold the previous thresholds.
        load_settings(2 * UNITY_Q16, THR_MAX, 1, 40000, 32768);
        queue_frame(24'h123456, -24'sd6636321, 1'b0);
        queue_frame(-24'sd5592406, 24'h2AAAAA, 1'b0);
        queue_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        queue_frame(24'h0F0F0F, -24'sd986895, 1'b0);
        drain_block();

        // Random phases: new settings each time, pacing rotated so that
        // gaps and stalls land at every stage of the frame pipeline.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(3))
                0:       g = UNITY_Q16;
                1:       g = longint'($urandom_range(32'hFFFF_FFFF, 0)) & 20'hFFFFF;
                2:       g = longint'($urandom_range(4 * 65536));
                default: g = longint'($urandom_range(2 * 65536, 65536 / 4));
            endcase
            case ($urandom_range(4))
                0:       v = longint'($urandom_range(17'h1FFFF));
                1:       v = longint'($urandom_range(65536));
                2:       v = UNITY_Q16;
                3:       v = 0;
                default: v = longint'($urandom_range(60000, 30000));
            endcase
            case ($urandom_range(3))
                0:       w = UNITY_Q16;
                1:       w = longint'($urandom_range(65536));
                2:       w = longint'($urandom_range(17'h1FFFF));
                default: w = 0;
            endcase
            load_settings(g, pick_threshold(), pick_threshold(), v, w);
            set_pacing(pacing_t'(ph % 4));
            queue_program(FRAMES_PER_PHASE);
            drain_block();
        end

        if (mismatch_count == 0 && clipped_frames_due.size() == 0) begin
            $display("stereo_one_corner_soft_clipper_core verification clean");
        end else begin
            $display("stereo_one_corner_soft_clipper_core verification failed");
        end
        $finish;
    end

endmodule

@@ stereo_one_corner_soft_clipper_core.f @@
rtl/socc_pkg.sv
rtl/socc_cfg.sv
rtl/socc_lane.sv
rtl/socc_merge.sv
rtl/stereo_one_corner_soft_clipper_core.sv
verif/tb_stereo_one_corner_soft_clipper_core.sv
